// ===== rtl/tpu_pkg.sv =====
package tpu_pkg;

	// privilege levels
	localparam logic [1:0] PRIV_U = 2'd0;
	localparam logic [1:0] PRIV_S = 2'd1;
	localparam logic [1:0] PRIV_M = 2'd3;
	localparam logic [1:0] PRIV_RSVD = 2'd2;

	// mstatus bit positions
	localparam int unsigned ST_SIE = 1;
	localparam int unsigned ST_MIE = 3;
	localparam int unsigned ST_SPIE = 5;
	localparam int unsigned ST_MPIE = 7;
	localparam int unsigned ST_SPP = 8;
	localparam int unsigned ST_MPP_LO = 11;
	localparam int unsigned ST_MPP_HI = 12;

	// masks
	localparam logic [31:0] MST_WRITABLE = 32'h007F_F9BB;
	localparam logic [31:0] SST_MASK = 32'h000D_E133;
	localparam logic [11:0] S_IRQS = 12'h222;
	localparam logic [11:0] M_IRQS = 12'hAAA;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IRQ_W = 12;

	// event codes on the mode field
	typedef enum logic [2:0] {
		MODE_EXC = 3'd0,
		MODE_IRQ = 3'd1,
		MODE_MRET = 3'd2,
		MODE_SRET = 3'd3,
		MODE_MSTATUS_WR = 3'd4,
		MODE_SSTATUS_WR = 3'd5
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXC_DELEG = 3'd0,
		CFG_IRQ_DELEG = 3'd1,
		CFG_MTVEC = 3'd2,
		CFG_STVEC = 3'd3,
		CFG_M_IRQ_EN = 3'd4,
		CFG_S_IRQ_EN = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] exc_deleg;
		logic [IRQ_W-1:0] irq_deleg;
		logic [31:0] mtvec;
		logic [31:0] stvec;
		logic [IRQ_W-1:0] m_irq_en;
		logic [IRQ_W-1:0] s_irq_en;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] exc_cause;
		logic [31:0] trap_value;
		logic [31:0] current_pc;
		logic [31:0] write_data;
		logic [IRQ_W-1:0] pending_irqs;
	} item_t;

	typedef struct packed {
		logic redirect;
		logic [31:0] target_pc;
		logic [1:0] priv_level;
		logic to_supervisor;
		logic [31:0] trap_cause;
		logic [31:0] mstatus_view;
		logic [31:0] sstatus_view;
	} result_t;

	typedef struct packed {
		logic hit;
		logic [3:0] num;
	} irq_pick_t;

	// fixed priority: MEI, MSI, MTI, SEI, SSI, STI
	function automatic irq_pick_t pick_irq(input logic [IRQ_W-1:0] p);
		irq_pick_t r;
		r.hit = 1'b1;
		if (p[11]) r.num = 4'd11;
		else if (p[3]) r.num = 4'd3;
		else if (p[7]) r.num = 4'd7;
		else if (p[9]) r.num = 4'd9;
		else if (p[1]) r.num = 4'd1;
		else if (p[5]) r.num = 4'd5;
		else begin
			r.hit = 1'b0;
			r.num = 4'd0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/tpu_cfg.sv =====
module tpu_cfg (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [tpu_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [31:0] wr_data,
	output tpu_pkg::cfg_t cfg
);

	tpu_pkg::cfg_t cfg_q;

	// configuration registers, delegation keeps only supervisor interrupts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				tpu_pkg::CFG_EXC_DELEG: cfg_q.exc_deleg <= wr_data;
				tpu_pkg::CFG_IRQ_DELEG: cfg_q.irq_deleg <= wr_data[tpu_pkg::IRQ_W-1:0] & tpu_pkg::S_IRQS;
				tpu_pkg::CFG_MTVEC: cfg_q.mtvec <= wr_data;
				tpu_pkg::CFG_STVEC: cfg_q.stvec <= wr_data;
				tpu_pkg::CFG_M_IRQ_EN: cfg_q.m_irq_en <= wr_data[tpu_pkg::IRQ_W-1:0];
				tpu_pkg::CFG_S_IRQ_EN: cfg_q.s_irq_en <= wr_data[tpu_pkg::IRQ_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tpu_exec.sv =====
module tpu_exec (
	input logic clk,
	input logic arst_n,
	input logic en,
	input tpu_pkg::item_t item,
	input tpu_pkg::cfg_t cfg,
	output tpu_pkg::result_t res
);

	logic [31:0] status_q, status_d;
	logic [1:0] priv_q, priv_d;
	logic [31:0] mepc_q, mepc_d, sepc_q, sepc_d;
	logic [31:0] mcause_q, mcause_d, scause_q, scause_d;
	logic [31:0] mtval_q, mtval_d, stval_q, stval_d;

	logic trap_m, trap_s;
	logic [31:0] t_cause, t_val;
	logic m_on, s_on, del;
	logic [tpu_pkg::IRQ_W-1:0] mp, sp;
	tpu_pkg::irq_pick_t m_pick, s_pick;
	logic [31:0] st_m, st_s, st_w;
	logic [1:0] mpp;

	// interrupt candidates at each level
	assign mp = item.pending_irqs & cfg.m_irq_en & ~cfg.irq_deleg & tpu_pkg::M_IRQS;
	assign sp = item.pending_irqs & cfg.s_irq_en & cfg.irq_deleg;
	assign m_on = (priv_q != tpu_pkg::PRIV_M) || status_q[tpu_pkg::ST_MIE];
	assign s_on = (priv_q == tpu_pkg::PRIV_U) ||
		((priv_q == tpu_pkg::PRIV_S) && status_q[tpu_pkg::ST_SIE]);
	assign m_pick = tpu_pkg::pick_irq(mp);
	assign s_pick = tpu_pkg::pick_irq(sp);
	assign del = (priv_q != tpu_pkg::PRIV_M) && cfg.exc_deleg[item.exc_cause];
	assign mpp = status_q[tpu_pkg::ST_MPP_HI:tpu_pkg::ST_MPP_LO];

	// status after a trap into each level
	always_comb begin
		st_m = status_q;
		st_m[tpu_pkg::ST_MPP_HI:tpu_pkg::ST_MPP_LO] = priv_q;
		st_m[tpu_pkg::ST_MPIE] = status_q[tpu_pkg::ST_MIE];
		st_m[tpu_pkg::ST_MIE] = 1'b0;
		st_s = status_q;
		st_s[tpu_pkg::ST_SPP] = (priv_q == tpu_pkg::PRIV_S);
		st_s[tpu_pkg::ST_SPIE] = status_q[tpu_pkg::ST_SIE];
		st_s[tpu_pkg::ST_SIE] = 1'b0;
		st_w = item.write_data & tpu_pkg::MST_WRITABLE;
		if (st_w[tpu_pkg::ST_MPP_HI:tpu_pkg::ST_MPP_LO] == tpu_pkg::PRIV_RSVD)
			st_w[tpu_pkg::ST_MPP_HI:tpu_pkg::ST_MPP_LO] = tpu_pkg::PRIV_U;
	end

	// event decode and next state
	always_comb begin
		status_d = status_q;
		priv_d = priv_q;
		mepc_d = mepc_q;
		sepc_d = sepc_q;
		mcause_d = mcause_q;
		scause_d = scause_q;
		mtval_d = mtval_q;
		stval_d = stval_q;
		trap_m = 1'b0;
		trap_s = 1'b0;
		t_cause = '0;
		t_val = '0;
		res = '0;
		case (item.mode)
			tpu_pkg::MODE_EXC: begin
				t_cause = {27'd0, item.exc_cause};
				t_val = item.trap_value;
				trap_s = del;
				trap_m = !del;
			end
			tpu_pkg::MODE_IRQ: begin
				if (m_on && m_pick.hit) begin
					trap_m = 1'b1;
					t_cause = {1'b1, 27'd0, m_pick.num};
				end else if (s_on && s_pick.hit) begin
					trap_s = 1'b1;
					t_cause = {1'b1, 27'd0, s_pick.num};
				end
			end
			tpu_pkg::MODE_MRET: begin
				status_d[tpu_pkg::ST_MIE] = status_q[tpu_pkg::ST_MPIE];
				status_d[tpu_pkg::ST_MPIE] = 1'b1;
				status_d[tpu_pkg::ST_MPP_HI:tpu_pkg::ST_MPP_LO] = tpu_pkg::PRIV_U;
				priv_d = (mpp == tpu_pkg::PRIV_RSVD) ? tpu_pkg::PRIV_U : mpp;
				res.redirect = 1'b1;
				res.target_pc = mepc_q;
			end
			tpu_pkg::MODE_SRET: begin
				status_d[tpu_pkg::ST_SIE] = status_q[tpu_pkg::ST_SPIE];
				status_d[tpu_pkg::ST_SPIE] = 1'b1;
				status_d[tpu_pkg::ST_SPP] = 1'b0;
				priv_d = status_q[tpu_pkg::ST_SPP] ? tpu_pkg::PRIV_S : tpu_pkg::PRIV_U;
				res.redirect = 1'b1;
				res.target_pc = sepc_q;
			end
			tpu_pkg::MODE_MSTATUS_WR: status_d = st_w;
			tpu_pkg::MODE_SSTATUS_WR: begin
				status_d = (status_q & ~tpu_pkg::SST_MASK) |
					(item.write_data & tpu_pkg::SST_MASK);
			end
			default: ;
		endcase

		// trap entry
		if (trap_m) begin
			status_d = st_m;
			priv_d = tpu_pkg::PRIV_M;
			mepc_d = item.current_pc;
			mcause_d = t_cause;
			mtval_d = t_val;
			res.redirect = 1'b1;
			res.target_pc = {cfg.mtvec[31:2], 2'b00};
			res.trap_cause = t_cause;
		end else if (trap_s) begin
			status_d = st_s;
			priv_d = tpu_pkg::PRIV_S;
			sepc_d = item.current_pc;
			scause_d = t_cause;
			stval_d = t_val;
			res.redirect = 1'b1;
			res.to_supervisor = 1'b1;
			res.target_pc = {cfg.stvec[31:2], 2'b00};
			res.trap_cause = t_cause;
		end

		res.priv_level = priv_d;
		res.mstatus_view = status_d;
		res.sstatus_view = status_d & tpu_pkg::SST_MASK;
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			priv_q <= tpu_pkg::PRIV_M;
			mepc_q <= '0;
			sepc_q <= '0;
			mcause_q <= '0;
			scause_q <= '0;
			mtval_q <= '0;
			stval_q <= '0;
		end else if (en) begin
			status_q <= status_d;
			priv_q <= priv_d;
			mepc_q <= mepc_d;
			sepc_q <= sepc_d;
			mcause_q <= mcause_d;
			scause_q <= scause_d;
			mtval_q <= mtval_d;
			stval_q <= stval_d;
		end
	end

endmodule

// ===== rtl/trap_and_privilege_unit.sv =====
// trap and privilege unit: one event per request, one result per request
// out_valid rises once an accepted request has passed the input register and then the result register
// throughput: one request per cycle while the result side is not stalled
// state updates in the cycle a request moves from the input register to the result register
// reset: status and trap registers clear, privilege goes to machine, config clears,
// both stages empty
module trap_and_privilege_unit (
	input logic clk,
	input logic arst_n,
	// request channel
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] mode,
	input logic [4:0] exc_cause,
	input logic [31:0] trap_value,
	input logic [31:0] current_pc,
	input logic [31:0] write_data,
	input logic [11:0] pending_irqs,
	// result channel
	output logic out_valid,
	input logic out_stall,
	output logic redirect,
	output logic [31:0] target_pc,
	output logic [1:0] priv_level,
	output logic to_supervisor,
	output logic [31:0] trap_cause,
	output logic [31:0] mstatus_view,
	output logic [31:0] sstatus_view,
	// configuration write channel
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tpu_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	tpu_pkg::cfg_t cfg;
	tpu_pkg::item_t item_s1;
	tpu_pkg::result_t res_comb, res_s2;
	logic valid_s1, valid_s2;
	logic advance, in_take;

	assign cfg_ready = 1'b1;

	tpu_cfg u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.wr_en (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data (cfg_data),
		.cfg (cfg)
	);

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= '{mode: mode, exc_cause: exc_cause, trap_value: trap_value,
				current_pc: current_pc, write_data: write_data, pending_irqs: pending_irqs};
		end
	end

	tpu_exec u_exec (
		.clk (clk),
		.arst_n (arst_n),
		.en (advance),
		.item (item_s1),
		.cfg (cfg),
		.res (res_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign redirect = res_s2.redirect;
	assign target_pc = res_s2.target_pc;
	assign priv_level = res_s2.priv_level;
	assign to_supervisor = res_s2.to_supervisor;
	assign trap_cause = res_s2.trap_cause;
	assign mstatus_view = res_s2.mstatus_view;
	assign sstatus_view = res_s2.sstatus_view;

	// privilege never lands on the reserved level
	a_priv_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> priv_level != tpu_pkg::PRIV_RSVD)
		else $error("reserved privilege level in result");

	// no redirect means no target and no cause
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !redirect) |-> (target_pc == '0 && trap_cause == '0 && !to_supervisor))
		else $error("non-redirect result carries trap fields");

	// a supervisor trap redirects and lands in supervisor mode
	a_to_s: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && to_supervisor) |-> (redirect && priv_level == tpu_pkg::PRIV_S))
		else $error("supervisor trap with wrong privilege");

	// input stalls only while both stages are full and the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("request stalled without back pressure");

	// a sstatus view is always a masked copy of mstatus
	a_view: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sstatus_view == (mstatus_view & tpu_pkg::SST_MASK))
		else $error("sstatus view out of step with mstatus");

endmodule
